[rtl/crs_pkg.sv]
`timescale 1ns / 1ps
// crs_pkg: types and constants shared by the slash and newline collapsing filter
// no dependencies

package crs_pkg;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;

    localparam logic [1:0] RUN_MAX       = 2'd3;
    localparam logic [2:0] TAIL_FILL_MAX = 3'd6;
    localparam logic [2:0] PFX5_LEN      = 3'd5;
    localparam logic [2:0] PFX6_LEN      = 3'd6;

    localparam logic [39:0] PFX_HTTP  = "http:";
    localparam logic [47:0] PFX_HTTPS = "https:";
    localparam logic [39:0] PFX_FILE  = "file:";

    localparam logic [1:0] ALLOW_PLAIN = 2'd1;
    localparam logic [1:0] ALLOW_HTTP  = 2'd2;
    localparam logic [1:0] ALLOW_FILE  = 2'd3;

    localparam logic [1:0] MAX_NEWLINES_RESET = 2'd1;

    typedef struct packed {
        logic [1:0]  newline_run;
        logic [47:0] emitted_tail;
        logic [2:0]  tail_fill;
        logic        in_slash_run;
        logic [1:0]  slashes_kept;
        logic [1:0]  slashes_allowed;
    } crs_state_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       kept;
        logic       out_text_end;
    } crs_result_t;

endpackage

[rtl/crs_ifs.sv]
`timescale 1ns / 1ps
// crs_ifs: valid/ready channel interfaces for text input, filtered output and config
// depends on nothing

interface crs_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       text_end;

    modport source (output valid, output in_char, output text_end, input ready);
    modport sink   (input valid, input in_char, input text_end, output ready);
endinterface

interface crs_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       kept;
    logic       out_text_end;

    modport source (output valid, output out_char, output kept, output out_text_end,
                    input ready);
    modport sink   (input valid, input out_char, input kept, input out_text_end,
                    output ready);
endinterface

interface crs_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] max_newlines;

    modport source (output valid, output max_newlines, input ready);
    modport sink   (input valid, input max_newlines, output ready);
endinterface

[rtl/crs_filter.sv]
`timescale 1ns / 1ps
// crs_filter: combinational keep/drop decision and next running state for one byte
// depends on crs_pkg

module crs_filter
    import crs_pkg::*;
(
    input  crs_state_t  cur,
    input  logic [1:0]  max_newlines,
    input  logic [7:0]  in_char,
    input  logic        text_end,
    output crs_state_t  nxt,
    output crs_result_t result
);

    logic is_http;
    logic is_https;
    logic is_file;
    logic keep;
    crs_state_t work;

    assign is_http  = (cur.tail_fill >= PFX5_LEN) && (cur.emitted_tail[39:0] == PFX_HTTP);
    assign is_https = (cur.tail_fill >= PFX6_LEN) && (cur.emitted_tail == PFX_HTTPS);
    assign is_file  = (cur.tail_fill >= PFX5_LEN) && (cur.emitted_tail[39:0] == PFX_FILE);

    always_comb
    begin
        work = cur;
        keep = 1'b0;
        if (in_char == CH_NEWLINE)
        begin
            if (cur.newline_run != RUN_MAX)
            begin
                work.newline_run = cur.newline_run + 2'd1;
            end
            keep = (work.newline_run <= max_newlines);
            work.in_slash_run = 1'b0;
        end
        else
        begin
            work.newline_run = '0;
            if (in_char != CH_SLASH)
            begin
                keep = 1'b1;
                work.in_slash_run = 1'b0;
            end
            else
            begin
                // run length fixed at first slash
                if (!cur.in_slash_run)
                begin
                    if (is_http || is_https)
                    begin
                        work.slashes_allowed = ALLOW_HTTP;
                    end
                    else if (is_file)
                    begin
                        work.slashes_allowed = ALLOW_FILE;
                    end
                    else
                    begin
                        work.slashes_allowed = ALLOW_PLAIN;
                    end
                    work.slashes_kept = '0;
                    work.in_slash_run = 1'b1;
                end
                if (work.slashes_kept < work.slashes_allowed)
                begin
                    keep = 1'b1;
                    work.slashes_kept = work.slashes_kept + 2'd1;
                end
            end
        end

        if (keep)
        begin
            work.emitted_tail = {cur.emitted_tail[39:0], in_char};
            if (cur.tail_fill != TAIL_FILL_MAX)
            begin
                work.tail_fill = cur.tail_fill + 3'd1;
            end
        end

        nxt = work;
        if (text_end)
        begin
            nxt = '0;
            nxt.newline_run = max_newlines;
        end

        result.out_char     = keep ? in_char : 8'd0;
        result.kept         = keep;
        result.out_text_end = text_end;
    end

endmodule

[rtl/collapse_repeated_slashes.sv]
`timescale 1ns / 1ps
// collapse_repeated_slashes: top level of the slash and newline collapsing byte filter
// depends on crs_pkg, crs_ifs, crs_filter
//
// Takes one byte per cycle while input is ready and returns one registered result per
// byte, saying whether it is kept. The running state (newline run, slash run, six-byte
// tail of emitted bytes) is updated in the same cycle the byte is taken, so bytes follow
// back to back, but a config write in that cycle takes priority and the byte's update
// is lost. Results go through an output register backed by a one-entry skid register,
// so the input stays ready while one result waits; input ready drops only when both are
// full. Config writes are always ready and also load the newline run, as at the start of a text.

module collapse_repeated_slashes
    import crs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    crs_text_if.sink            text,
    crs_result_if.source        filtered,
    crs_cfg_if.sink             cfg
);

    crs_state_t  state_reg;
    crs_state_t  state_next;
    crs_result_t result_next;
    crs_result_t out_reg;
    crs_result_t skid_reg;
    logic        out_valid_reg;
    logic        skid_valid_reg;
    logic [1:0]  max_newlines_reg;
    logic        in_fire;
    logic        out_fire;
    logic        cfg_fire;
    logic        out_free;

    crs_filter u_filter (
        .cur          (state_reg),
        .max_newlines (max_newlines_reg),
        .in_char      (text.in_char),
        .text_end     (text.text_end),
        .nxt          (state_next),
        .result       (result_next)
    );

    assign text.ready = !skid_valid_reg;
    assign cfg.ready  = 1'b1;
    assign in_fire    = text.valid && text.ready;
    assign out_fire   = out_valid_reg && filtered.ready;
    assign cfg_fire   = cfg.valid;
    assign out_free   = !out_valid_reg || out_fire;

    assign filtered.valid        = out_valid_reg;
    assign filtered.out_char     = out_reg.out_char;
    assign filtered.kept         = out_reg.kept;
    assign filtered.out_text_end = out_reg.out_text_end;

    // running state and config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_newlines_reg <= MAX_NEWLINES_RESET;
            state_reg        <= '{newline_run: MAX_NEWLINES_RESET, default: '0};
        end
        else if (cfg_fire)
        begin
            max_newlines_reg      <= cfg.max_newlines;
            state_reg.newline_run <= cfg.max_newlines;
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
        end
    end

    // output register with skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (out_free)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (in_fire)
            begin
                if (out_free)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_free)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (in_fire)
        begin
            if (out_free)
            begin
                out_reg <= result_next;
            end
            else
            begin
                skid_reg <= result_next;
            end
        end
    end

endmodule
